### src/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ST_ADDR_W  = 16;
  localparam int X_W        = 27;
  localparam int SB_W       = 18;
  localparam int TB_W       = 27;
  localparam int SR_W       = 12;
  localparam int DR_W       = 21;
  localparam int PROD_X_W   = X_W + SR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  // Divide by 100 as multiply by reciprocal; exact over the full register range.
  localparam int                      SRC_RECIP_W = 19;
  localparam logic [SRC_RECIP_W-1:0]  SRC_RECIP   = 19'd335545;
  localparam int                      SRC_SHIFT   = 25;
  localparam int                      TGT_RECIP_W = 28;
  localparam logic [TGT_RECIP_W-1:0]  TGT_RECIP   = 28'd171798692;
  localparam int                      TGT_SHIFT   = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDE_SAMPLES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE  = 2'd3;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic                       command;
    logic [ST_ADDR_W-1:0]       store_address;
    logic signed [SAMPLE_W-1:0] store_sample;
    logic [X_W-1:0]             output_index;
  } lir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result_sample;
    logic                       held_value;
  } lir_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_MOD,
    ST_RD_A,
    ST_RD_B,
    ST_MIX,
    ST_FIN
  } lir_state_t;

endpackage

`default_nettype wire

### src/lir_stream_if.sv
// Valid/ready stream channel carrying one payload struct per beat.
`default_nettype none

interface lir_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/lir_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/lir_div.sv
// Restoring divider, one quotient bit per cycle, with a selectable step count.
`default_nettype none

module lir_div #(
  parameter int N_W = 42,
  parameter int D_W = 21
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [$clog2(N_W+1)-1:0]   steps,
  input  wire logic [N_W-1:0]             dividend,
  input  wire logic [D_W-1:0]             divisor,
  output logic                            done,
  output logic      [N_W-1:0]             quotient,
  output logic      [D_W-1:0]             remainder
);

  localparam int C_W = $clog2(N_W+1);

  logic           busy_r;
  logic           done_r;
  logic [C_W-1:0] cnt_r;
  logic [N_W-1:0] dvd_r;
  logic [D_W-1:0] dvs_r;
  logic [D_W-1:0] rem_r;

  logic [D_W:0]   shifted;
  logic [D_W:0]   diff;
  logic           ge;

  assign shifted = {rem_r, dvd_r[N_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - C_W'(1);
        if (cnt_r == C_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      dvd_r <= {dvd_r[N_W-2:0], ge};
      rem_r <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### src/linear_interp_resampler.sv
// Top level: sample store, position divider and interpolation sequencer.
`default_nettype none

// Linear interpolation resampler. A store beat (command 0) writes one sample into
// the sample store. A read beat (command 1) computes output element output_index:
// the position (x * (source_bytes/100) << FRACTION_BITS) / (target_bytes/100)
// runs through a one-bit-per-cycle divider, then the two neighbor samples are read
// from the store on its single read port and mixed. When STORE_DEPTH is not a
// power of two and is below 2^18, the element index is reduced modulo the depth on
// the same divider. Reads past the source end, or with target_bytes/100 equal to
// zero, repeat the channel's last value and flag held_value. One item is in work
// at a time; a finished result waits in the output register while the next input
// beat is taken. Configuration is written through cfg_we/cfg_index/cfg_wdata; the
// user must write it only while the block is idle; the block does not enforce it.
module linear_interp_resampler #(
  parameter int STORE_DEPTH   = 65536,
  parameter int FRACTION_BITS = 3
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [lir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lir_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  lir_stream_if.sink                           in_bus,
  lir_stream_if.source                         out_bus
);

  import lir_pkg::*;

  localparam int FB       = FRACTION_BITS;
  localparam int AW       = $clog2(STORE_DEPTH);
  localparam int ADDR_X_W = (AW > ST_ADDR_W) ? AW : ST_ADDR_W;
  localparam int NUM_W    = PROD_X_W + FB;
  localparam int BASE_W   = PROD_X_W;
  localparam int FIRST_W  = BASE_W + 1;
  localparam int DEPTH_W  = $clog2(STORE_DEPTH + 1);
  localparam int DVS_W    = (DEPTH_W > DR_W) ? DEPTH_W : DR_W;
  localparam int CNT_W    = $clog2(NUM_W + 1);
  localparam int MIX_W    = SAMPLE_W + FB + 2;
  localparam int MOD_W    = SB_W;
  localparam int SRCP_W   = SB_W + SRC_RECIP_W;
  localparam int TGTP_W   = TB_W + TGT_RECIP_W;
  localparam bit NEED_MOD = ((STORE_DEPTH & (STORE_DEPTH - 1)) != 0) &&
                            (STORE_DEPTH < (1 << MOD_W));

  function automatic logic signed [SAMPLE_W-1:0] narrow(input logic [SAMPLE_W-1:0] v,
                                                        input logic wide);
    narrow = wide ? v : {{(SAMPLE_W-8){v[7]}}, v[7:0]};
  endfunction

  // configuration
  logic [SB_W-1:0] src_bytes_r;
  logic [TB_W-1:0] tgt_bytes_r;
  logic            wide_r;
  logic            stereo_r;

  // sequencer and datapath
  lir_state_t                 state_r, state_nxt;
  logic                       chan_r;
  logic [X_W-1:0]             xb_r;
  logic [SR_W-1:0]            sr_r;
  logic [DR_W-1:0]            dr_r;
  logic [SB_W-1:0]            limit_r;
  logic [FB-1:0]              frac_r;
  logic [AW-1:0]              idx_a_r;
  logic [AW-1:0]              idx_b_r;
  logic signed [MIX_W-1:0]    wa_r;
  logic [SAMPLE_W-1:0]        mix_r;
  logic                       past_r;
  logic [SAMPLE_W-1:0]        hold_left_r;
  logic [SAMPLE_W-1:0]        hold_right_r;
  logic                       out_valid_r;
  lir_out_t                   out_data_r;

  // divider hookup
  logic                div_start;
  logic [CNT_W-1:0]    div_steps;
  logic [NUM_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic                div_done;
  logic [NUM_W-1:0]    div_quot;
  logic [DVS_W-1:0]    div_rem;

  // memory hookup
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [ADDR_X_W-1:0] st_addr_x;

  // combinational datapath
  logic                 in_fire;
  logic                 fin_fire;
  logic [SRCP_W-1:0]    sr_prod;
  logic [TGTP_W-1:0]    dr_prod;
  logic [PROD_X_W-1:0]  num_c;
  logic [BASE_W-1:0]    base_c;
  logic [1:0]           step_c;
  logic [FIRST_W-1:0]   first_c;
  logic [FIRST_W-1:0]   first_end_c;
  logic                 past_c;
  logic [AW:0]          mod_b_sum;
  logic [AW:0]          mod_b_wrap;
  logic [FB:0]          w_lo;
  logic signed [SAMPLE_W-1:0] rd_ext;
  logic signed [MIX_W-1:0]    mix_c;
  logic [SAMPLE_W-1:0]  fin_val;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign fin_fire = (state_r == ST_FIN) && (!out_valid_r || out_bus.ready);

  assign sr_prod = SRCP_W'(src_bytes_r) * SRCP_W'(SRC_RECIP);
  assign dr_prod = TGTP_W'(tgt_bytes_r) * TGTP_W'(TGT_RECIP);
  assign num_c   = PROD_X_W'(xb_r) * PROD_X_W'(sr_r);

  assign step_c = stereo_r ? 2'd2 : 2'd1;
  always_comb begin
    base_c = div_quot[NUM_W-1:FB];
    if (stereo_r) begin
      base_c[0] = 1'b0;
    end
  end
  assign first_c     = FIRST_W'(base_c) + FIRST_W'(chan_r);
  assign first_end_c = first_c + FIRST_W'(step_c);
  assign past_c      = first_end_c >= FIRST_W'(limit_r);

  assign mod_b_sum  = {1'b0, div_rem[AW-1:0]} + (AW+1)'(step_c);
  assign mod_b_wrap = (mod_b_sum >= (AW+1)'(STORE_DEPTH)) ?
                      (mod_b_sum - (AW+1)'(STORE_DEPTH)) : mod_b_sum;

  assign w_lo   = (FB+1)'(1 << FB) - {1'b0, frac_r};
  assign rd_ext = narrow(ram_rdata, wide_r);
  assign mix_c  = wa_r + $signed({1'b0, frac_r}) * rd_ext;

  assign fin_val = past_r ? (chan_r ? hold_right_r : hold_left_r) : mix_r;

  // store path
  assign st_addr_x = ADDR_X_W'(in_bus.data.store_address);
  assign ram_waddr = st_addr_x[AW-1:0];
  assign ram_we    = in_fire && (in_bus.data.command == CMD_STORE) &&
                     (32'(in_bus.data.store_address) < 32'(STORE_DEPTH));
  assign ram_raddr = (state_r == ST_RD_B) ? idx_b_r : idx_a_r;

  assign in_bus.ready  = (state_r == ST_IDLE);
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_data_r;

  lir_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_bus.data.store_sample),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lir_div #(
    .N_W (NUM_W),
    .D_W (DVS_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .steps     (div_steps),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_bytes_r <= '0;
      tgt_bytes_r <= TB_W'(100);
      wide_r      <= 1'b0;
      stereo_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_BYTES: src_bytes_r <= cfg_wdata[SB_W-1:0];
        CFG_TARGET_BYTES: tgt_bytes_r <= cfg_wdata[TB_W-1:0];
        CFG_WIDE_SAMPLES: wide_r      <= cfg_wdata[0];
        CFG_STEREO_MODE:  stereo_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_steps    = CNT_W'(NUM_W);
    div_dividend = {num_c, {FB{1'b0}}};
    div_divisor  = DVS_W'(dr_r);
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_bus.data.command == CMD_READ) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL: begin
        if (dr_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (past_c) begin
            state_nxt = ST_FIN;
          end else if (NEED_MOD) begin
            // reduce the element index modulo the store depth
            div_start    = 1'b1;
            div_steps    = CNT_W'(MOD_W);
            div_dividend = {first_c[MOD_W-1:0], {(NUM_W-MOD_W){1'b0}}};
            div_divisor  = DVS_W'(STORE_DEPTH);
            state_nxt    = ST_MOD;
          end else begin
            state_nxt = ST_RD_A;
          end
        end
      end
      ST_MOD: begin
        if (div_done) begin
          state_nxt = ST_RD_A;
        end
      end
      ST_RD_A: state_nxt = ST_RD_B;
      ST_RD_B: state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        chan_r <= stereo_r & in_bus.data.output_index[0];
        xb_r   <= stereo_r ? {in_bus.data.output_index[X_W-1:1], 1'b0}
                           : in_bus.data.output_index;
      end
      ST_PREP: begin
        sr_r    <= sr_prod[SRCP_W-1:SRC_SHIFT];
        dr_r    <= dr_prod[TGTP_W-1:TGT_SHIFT];
        limit_r <= wide_r ? (src_bytes_r >> 1) : src_bytes_r;
        past_r  <= 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          past_r  <= past_c;
          frac_r  <= div_quot[FB-1:0];
          idx_a_r <= first_c[AW-1:0];
          idx_b_r <= first_end_c[AW-1:0];
        end
      end
      ST_MOD: begin
        if (div_done) begin
          idx_a_r <= div_rem[AW-1:0];
          idx_b_r <= mod_b_wrap[AW-1:0];
        end
      end
      ST_RD_B: wa_r  <= $signed({1'b0, w_lo}) * rd_ext;
      ST_MIX:  mix_r <= mix_c[FB+SAMPLE_W-1:FB];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_left_r  <= '0;
      hold_right_r <= '0;
    end else if (fin_fire && !past_r) begin
      if (chan_r) begin
        hold_right_r <= mix_r;
      end else begin
        hold_left_r <= mix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_data_r.result_sample <= narrow(fin_val, wide_r);
      out_data_r.held_value    <= past_r;
    end
  end

endmodule

`default_nettype wire

### dv/linear_interp_resampler_checker.sv
// Scoreboard for the resampler: mirrors the sample store and channel holds, checks each result beat.
`timescale 1ns / 100ps

module linear_interp_resampler_checker
  import lir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  lir_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  lir_out_t              out_data,
  output int                    results_due,
  output int                    fail_count
);

  localparam int          FRAC_BITS   = 3;
  localparam int          STORE_WORDS = 65536;
  localparam logic [63:0] FRAC_ONE    = 64'd1 << FRAC_BITS;

  logic [SAMPLE_W-1:0] sample_mem [STORE_WORDS];
  logic [SAMPLE_W-1:0] hold_left;
  logic [SAMPLE_W-1:0] hold_right;
  logic [SB_W-1:0]     src_bytes;
  logic [TB_W-1:0]     tgt_bytes;
  logic                wide;
  logic                stereo;
  lir_out_t            pending_results [$];
  int                  errors = 0;

  // Element as a two's-complement value at the current sample width.
  function automatic logic [63:0] sample_at(logic [63:0] idx);
    logic [SAMPLE_W-1:0] w;
    w = sample_mem[idx[15:0]];
    if (wide) return {{48{w[15]}}, w};
    return {{56{w[7]}}, w[7:0]};
  endfunction

  // Interpolated element for output index x; refreshes the channel hold unless the result is a held value.
  function automatic lir_out_t resample(logic [X_W-1:0] x);
    logic [63:0]         xb, sr, dr, lim, pos, frac, first, step, acc;
    logic [SAMPLE_W-1:0] val;
    logic                chan, past;
    lir_out_t            res;
    chan = stereo & x[0];
    xb   = 64'(x);
    if (stereo) xb[0] = 1'b0;
    sr   = src_bytes / 100;
    dr   = tgt_bytes / 100;
    lim  = wide ? src_bytes / 2 : src_bytes;
    step = stereo ? 64'd2 : 64'd1;
    past = 1'b1;
    if (dr != 0) begin
      pos   = ((xb * sr) << FRAC_BITS) / dr;
      frac  = pos & (FRAC_ONE - 1);
      first = pos >> FRAC_BITS;
      if (stereo) first[0] = 1'b0;
      first = first + chan;
      past  = (first + step >= lim);
      if (!past) begin
        acc = (FRAC_ONE - frac) * sample_at(first) + frac * sample_at(first + step);
        val = acc[FRAC_BITS +: SAMPLE_W];
        if (chan) hold_right = val;
        else hold_left = val;
      end
    end
    val = chan ? hold_right : hold_left;
    if (!wide) val = {{8{val[7]}}, val[7:0]};
    res.result_sample = val;
    res.held_value    = past;
    return res;
  endfunction

  always @(posedge clk) begin
    lir_out_t want;
    if (!rst_n) begin
      hold_left  = '0;
      hold_right = '0;
      src_bytes  = '0;
      tgt_bytes  = TB_W'(100);
      wide       = 1'b0;
      stereo     = 1'b0;
      pending_results.delete();
    end else begin
      // a result beat never belongs to the input beat taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: result_sample %0d held_value %0b",
                 out_data.result_sample, out_data.held_value);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.result_sample !== want.result_sample) begin
            $error("result_sample: expected %0d, actual %0d",
                   want.result_sample, out_data.result_sample);
            errors++;
          end
          if (out_data.held_value !== want.held_value) begin
            $error("held_value: expected %0b, actual %0b",
                   want.held_value, out_data.held_value);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_BYTES: src_bytes = cfg_wdata[SB_W-1:0];
          CFG_TARGET_BYTES: tgt_bytes = cfg_wdata[TB_W-1:0];
          CFG_WIDE_SAMPLES: wide = cfg_wdata[0];
          CFG_STEREO_MODE:  stereo = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_STORE) begin
          sample_mem[in_data.store_address] = in_data.store_sample;
        end else begin
          pending_results.push_back(resample(in_data.output_index));
        end
      end
    end
    results_due <= pending_results.size();
    fail_count  <= errors;
  end

endmodule

### dv/linear_interp_resampler_tb.sv
// Testbench top for the resampler: clock, reset, register setup, beat traffic and verdict.
`timescale 1ns / 100ps

module linear_interp_resampler_tb;
  import lir_pkg::*;

  localparam int          HOLD_OFF    = 100;
  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASE_BEATS = 35;
  localparam logic [63:0] MAX_X       = 64'd83886079;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  sink_ready = 1'b0;
  int                    src_gap_pct = 0;
  int                    sink_gap_pct = 0;
  int                    results_due;
  int                    fail_count;
  int                    quiet_cycles = 0;

  // register values as last programmed, used to aim reads at written samples
  logic [SB_W-1:0]       cur_src;
  logic [TB_W-1:0]       cur_tgt;
  logic                  cur_wide;
  logic                  cur_stereo;
  bit                    filled [65536];

  lir_stream_if #(.payload_t(lir_in_t))  in_bus ();
  lir_stream_if #(.payload_t(lir_out_t)) out_bus ();

  assign out_bus.ready = sink_ready;

  linear_interp_resampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  linear_interp_resampler_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_bus.valid),
    .in_ready    (in_bus.ready),
    .in_data     (in_bus.data),
    .out_valid   (out_bus.valid),
    .out_ready   (out_bus.ready),
    .out_data    (out_bus.data),
    .results_due (results_due),
    .fail_count  (fail_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= sink_gap_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid high across back-to-back beats; drop it only for a gap.
  task automatic send_beat(lir_in_t beat);
    while ($urandom_range(99) < src_gap_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= beat;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic put_sample(logic [ST_ADDR_W-1:0] addr, logic [SAMPLE_W-1:0] smp);
    lir_in_t beat;
    beat.command       = CMD_STORE;
    beat.store_address = addr;
    beat.store_sample  = smp;
    beat.output_index  = X_W'($urandom());
    filled[addr]       = 1'b1;
    send_beat(beat);
  endtask

  // Store any neighbor this read would fetch that has not been written yet.
  task automatic request_read(logic [X_W-1:0] x);
    logic [63:0] xb, sr, dr, lim, lo, hi;
    lir_in_t     beat;
    xb  = 64'(x);
    if (cur_stereo) xb[0] = 1'b0;
    sr  = cur_src / 100;
    dr  = cur_tgt / 100;
    lim = cur_wide ? cur_src / 2 : cur_src;
    if (dr != 0) begin
      lo = xb * sr / dr;
      if (cur_stereo) lo[0] = 1'b0;
      lo = lo + (cur_stereo & x[0]);
      hi = lo + (cur_stereo ? 64'd2 : 64'd1);
      if (hi < lim) begin
        if (!filled[lo[15:0]]) put_sample(lo[15:0], SAMPLE_W'($urandom()));
        if (!filled[hi[15:0]]) put_sample(hi[15:0], SAMPLE_W'($urandom()));
      end
    end
    beat.command       = CMD_READ;
    beat.store_address = ST_ADDR_W'($urandom());
    beat.store_sample  = SAMPLE_W'($urandom());
    beat.output_index  = x;
    send_beat(beat);
  endtask

  // Stop sending, collect every result, then let a trailing store settle.
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic program_regs(logic [SB_W-1:0] sb, logic [TB_W-1:0] tb,
                              logic wide, logic stereo);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_BYTES;
    cfg_wdata <= CFG_DATA_W'(sb);
    @(posedge clk);
    cfg_index <= CFG_TARGET_BYTES;
    cfg_wdata <= CFG_DATA_W'(tb);
    @(posedge clk);
    cfg_index <= CFG_WIDE_SAMPLES;
    cfg_wdata <= CFG_DATA_W'(wide);
    @(posedge clk);
    cfg_index <= CFG_STEREO_MODE;
    cfg_wdata <= CFG_DATA_W'(stereo);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_src    = sb;
    cur_tgt    = tb;
    cur_wide   = wide;
    cur_stereo = stereo;
  endtask

  task automatic random_phase(logic [SB_W-1:0] sb, logic [TB_W-1:0] tb,
                              logic wide, logic stereo);
    logic [63:0] lim, sr, dr, span, rim, x;
    int          pick;
    program_regs(sb, tb, wide, stereo);
    lim  = wide ? sb / 2 : sb;
    sr   = sb / 100;
    dr   = tb / 100;
    // span: reads below it land inside the source
    span = (sr == 0) ? MAX_X : lim * dr / sr;
    if (span > MAX_X) span = MAX_X;
    rim  = (span > 4) ? span - 4 : 0;
    repeat (PHASE_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        put_sample(ST_ADDR_W'($urandom()), SAMPLE_W'($urandom()));
      end else if (pick < 35) begin
        if (lim == 0) put_sample(ST_ADDR_W'($urandom()), SAMPLE_W'($urandom()));
        else put_sample(ST_ADDR_W'($urandom_range(32'((lim > 65536 ? 65536 : lim) - 1))),
                        SAMPLE_W'($urandom()));
      end else begin
        if (pick < 80) x = 64'($urandom_range(32'(span)));
        else if (pick < 90) x = rim + $urandom_range(8);
        else x = 64'($urandom_range(32'(MAX_X)));
        if (x > MAX_X) x = MAX_X;
        request_read(X_W'(x));
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_SOURCE_BYTES;
    cfg_wdata    <= '0;
    in_bus.valid <= 1'b0;
    in_bus.data  <= '0;
    cur_src      = '0;
    cur_tgt      = TB_W'(100);
    cur_wide     = 1'b0;
    cur_stereo   = 1'b0;
    src_gap_pct  = 27;
    sink_gap_pct = 68;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero source length: every read repeats the cleared hold
    request_read(X_W'(0));
    request_read(X_W'(MAX_X));

    // ratio 3/8 puts each of these reads on a different fraction; low bytes hit the sign extremes
    program_regs(SB_W'(300), TB_W'(800), 1'b0, 1'b0);
    put_sample(16'd0, 16'h8000);
    put_sample(16'd1, 16'h7FFF);
    put_sample(16'd2, 16'h0080);
    put_sample(16'd3, 16'hFF7F);
    put_sample(16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) request_read(X_W'(i));
    request_read(X_W'(797));
    request_read(X_W'(799));

    program_regs(SB_W'(300), TB_W'(800), 1'b1, 1'b0);
    request_read(X_W'(0));
    request_read(X_W'(1));
    request_read(X_W'(399));

    program_regs(SB_W'(300), TB_W'(800), 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) request_read(X_W'(i));
    request_read(X_W'(397));

    // target below 100: no division, hold shown at 8 bits
    program_regs(SB_W'(300), TB_W'(50), 1'b0, 1'b0);
    request_read(X_W'(5));

    // element index past the store depth wraps
    program_regs(SB_W'(131072), TB_W'(100), 1'b0, 1'b0);
    request_read(X_W'(60));
    request_read(X_W'(100));

    random_phase(SB_W'(1000), TB_W'(2300), 1'b0, 1'b0);
    random_phase(SB_W'(5000), TB_W'(1200), 1'b1, 1'b0);
    random_phase(SB_W'(131072), TB_W'(83886080), 1'b0, 1'b1);

    src_gap_pct  = 68;
    sink_gap_pct = 27;
    random_phase(SB_W'(0), TB_W'(100), 1'b1, 1'b1);
    random_phase(SB_W'(99), TB_W'(100), 1'b0, 1'b0);
    random_phase(SB_W'(100), TB_W'(83886080), 1'b1, 1'b0);

    src_gap_pct  = 0;
    sink_gap_pct = 0;
    random_phase(SB_W'(131072), TB_W'(100), 1'b1, 1'b0);
    random_phase(SB_W'(777), TB_W'(99), 1'b0, 1'b1);
    random_phase(SB_W'($urandom_range(131072)), TB_W'($urandom_range(83886080, 100)),
                 1'($urandom()), 1'($urandom()));

    drain_results();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
src/lir_pkg.sv
src/lir_stream_if.sv
src/lir_ram.sv
src/lir_div.sv
src/linear_interp_resampler.sv
dv/linear_interp_resampler_checker.sv
dv/linear_interp_resampler_tb.sv
